// ===== sv/icm_pkg.sv =====
// icm_pkg: shared types and constants for the icm label sweep block
// depends on nothing; used by every module of the block except icm_ram

package icm_pkg;

   localparam int MAX_VARS_DEF   = 1024;
   localparam int MAX_LABELS_DEF = 16;
   localparam int MAX_EDGES_DEF  = 8192;

   localparam int LABEL_W = 5;
   localparam int PTR_W   = 14;
   localparam int NB_W    = 10;
   localparam int COST_W  = 16;
   localparam int ACC_W   = 48;
   localparam int Q_SHIFT = 12;

   // item function codes
   typedef enum logic [2:0] {
      FN_UNARY = 3'd0,
      FN_PAIR  = 3'd1,
      FN_EDGE  = 3'd2,
      FN_COLP  = 3'd3,
      FN_LABEL = 3'd4,
      FN_SWEEP = 3'd5,
      FN_READ  = 3'd6,
      FN_NONE  = 3'd7
   } func_type;

   // result kinds
   localparam logic RK_READ  = 1'b0;
   localparam logic RK_SWEEP = 1'b1;

   // configuration register indexes
   localparam logic CSR_NUM_VARS   = 1'b0;
   localparam logic CSR_NUM_LABELS = 1'b1;

   // datapath operation, one per controller step
   typedef enum logic [4:0] {
      OP_CLEAR,
      OP_IDLE,
      OP_RD_CAP,
      OP_RD_OUT,
      OP_SW_START,
      OP_PTR_LO,
      OP_PTR_HI,
      OP_PTR_CAP,
      OP_U_ISS,
      OP_U_CAP,
      OP_E_CHK,
      OP_E_CAP,
      OP_L_CAP,
      OP_P_ISS,
      OP_P_CAP,
      OP_P_ADD,
      OP_MIN,
      OP_WRITE,
      OP_DONE
   } dp_op_type;

   typedef struct packed {
      logic clr_last;
      logic k_last;
      logic s_done;
      logic edge_ok;
      logic label_ok;
      logic col_last;
      logic nv_zero;
      logic out_free;
   } dp_status_type;

endpackage

// ===== sv/icm_ram.sv =====
// icm_ram: generic single-port-write, single-port-read ram, registered read
// depends on nothing

module icm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/icm_ctrl.sv =====
// icm_ctrl: sequencer for loads, label reads, clearing pass and the sweep
// depends on icm_pkg

module icm_ctrl
   import icm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [2:0]    req_func,
   input  dp_status_type status,
   output logic          req_stall,
   output dp_op_type     op
);

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_RD_CAP, ST_RD_OUT, ST_SW_START, ST_PLO, ST_PHI, ST_PHIC,
      ST_U_ISS, ST_U_CAP, ST_E_CHK, ST_E_CAP, ST_L_CAP, ST_P_ISS, ST_P_CAP,
      ST_P_ADD, ST_MIN, ST_WRITE, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_IDLE;
      case (state_ff)
         ST_CLR: begin
            op = OP_CLEAR;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            op = OP_IDLE;
            if (req_valid && req_func == FN_READ) state_in = ST_RD_CAP;
            if (req_valid && req_func == FN_SWEEP) state_in = ST_SW_START;
         end
         ST_RD_CAP: begin
            op = OP_RD_CAP;
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            op = OP_RD_OUT;
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_SW_START: begin
            op = OP_SW_START;
            state_in = status.nv_zero ? ST_DONE : ST_PLO;
         end
         ST_PLO: begin
            op = OP_PTR_LO;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            op = OP_PTR_HI;
            state_in = ST_PHIC;
         end
         ST_PHIC: begin
            op = OP_PTR_CAP;
            state_in = ST_U_ISS;
         end
         ST_U_ISS: begin
            op = OP_U_ISS;
            state_in = ST_U_CAP;
         end
         ST_U_CAP: begin
            op = OP_U_CAP;
            state_in = status.k_last ? ST_E_CHK : ST_U_ISS;
         end
         ST_E_CHK: begin
            op = OP_E_CHK;
            state_in = status.s_done ? ST_MIN : ST_E_CAP;
         end
         ST_E_CAP: begin
            op = OP_E_CAP;
            state_in = status.edge_ok ? ST_L_CAP : ST_E_CHK;
         end
         ST_L_CAP: begin
            op = OP_L_CAP;
            state_in = status.label_ok ? ST_P_ISS : ST_E_CHK;
         end
         ST_P_ISS: begin
            op = OP_P_ISS;
            state_in = ST_P_CAP;
         end
         ST_P_CAP: begin
            op = OP_P_CAP;
            state_in = ST_P_ADD;
         end
         ST_P_ADD: begin
            op = OP_P_ADD;
            state_in = status.k_last ? ST_E_CHK : ST_P_ISS;
         end
         ST_MIN: begin
            op = OP_MIN;
            if (status.k_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            op = OP_WRITE;
            state_in = status.col_last ? ST_DONE : ST_PLO;
         end
         ST_DONE: begin
            op = OP_DONE;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== sv/icm_dpath.sv =====
// icm_dpath: tables, label store, cost accumulators, counters and result register
// depends on icm_pkg and icm_ram

module icm_dpath
   import icm_pkg::*;
#(
   parameter int MAX_VARS   = MAX_VARS_DEF,
   parameter int MAX_LABELS = MAX_LABELS_DEF,
   parameter int MAX_EDGES  = MAX_EDGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_op_type           op,
   output dp_status_type       status,
   input  logic                req_valid,
   input  logic [2:0]          req_func,
   input  logic [10:0]         req_var_index,
   input  logic [4:0]          req_label_a,
   input  logic [4:0]          req_label_b,
   input  logic [12:0]         req_edge_slot,
   input  logic [13:0]         req_pointer_value,
   input  logic [9:0]          req_neighbor_index,
   input  logic signed [15:0]  req_cost,
   input  logic signed [15:0]  req_weight,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [10:0]         csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [4:0]          rsp_label
);

   localparam int VAW = $clog2(MAX_VARS);
   localparam int VCW = $clog2(MAX_VARS + 1);
   localparam int LAW = $clog2(MAX_LABELS);
   localparam int LCW = $clog2(MAX_LABELS + 1);
   localparam int UAW = $clog2(MAX_VARS * MAX_LABELS);
   localparam int PAW = $clog2(MAX_LABELS * MAX_LABELS);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int EW  = NB_W + COST_W;

   // memory ports
   logic               un_we, pr_we, ed_we, cp_we, lb_we;
   logic [UAW-1:0]     un_wa, un_ra;
   logic [PAW-1:0]     pr_wa, pr_ra;
   logic [EAW-1:0]     ed_wa, ed_ra;
   logic [VCW-1:0]     cp_wa, cp_ra;
   logic [VAW-1:0]     lb_wa, lb_ra;
   logic [LABEL_W-1:0] lb_wd, lb_rd;
   logic [COST_W-1:0]  un_rd, pr_rd;
   logic [EW-1:0]      ed_rd;
   logic [PTR_W-1:0]   cp_rd;

   // registers
   logic [10:0]              num_vars_ff, num_vars_in;
   logic [4:0]               num_labels_ff, num_labels_in;
   logic [VAW-1:0]           clr_ff, clr_in;
   logic [VCW-1:0]           col_ff, col_in;
   logic [LCW-1:0]           k_ff, k_in;
   logic [PTR_W-1:0]         s_ff, s_in, hi_ff, hi_in;
   logic signed [COST_W-1:0] w_ff, w_in;
   logic [LABEL_W-1:0]       lb_ff, lb_in;
   logic signed [31:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]  cost_ff [MAX_LABELS];
   logic signed [ACC_W-1:0]  cost_in [MAX_LABELS];
   logic signed [ACC_W-1:0]  best_ff, best_in;
   logic [LAW-1:0]           bi_ff, bi_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic [LABEL_W-1:0]       rdlab_ff, rdlab_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [LABEL_W-1:0]       rsp_label_ff, rsp_label_in;

   // effective register values
   logic [LCW-1:0]      nl;
   logic [VCW-1:0]      nv;
   logic                load;
   logic [NB_W-1:0]     ed_nb;
   logic [LAW-1:0]      k_idx;
   logic [PTR_W-1:0]    ptr_clamped;
   logic                out_free;

   assign nl = (num_labels_ff == 5'd0) ? LCW'(1) :
               (int'(num_labels_ff) > MAX_LABELS) ? LCW'(MAX_LABELS) : LCW'(num_labels_ff);
   assign nv = (int'(num_vars_ff) > MAX_VARS) ? VCW'(MAX_VARS) : VCW'(num_vars_ff);

   assign load     = (op == OP_IDLE) && req_valid;
   assign ed_nb    = ed_rd[EW-1 -: NB_W];
   assign k_idx    = k_ff[LAW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ptr_clamped = (int'(cp_rd) > MAX_EDGES) ? PTR_W'(MAX_EDGES) : cp_rd;

   // status toward the controller
   assign status.clr_last = (clr_ff == VAW'(MAX_VARS - 1));
   assign status.k_last   = (int'(k_ff) + 1 >= int'(nl));
   assign status.s_done   = (s_ff >= hi_ff);
   assign status.edge_ok  = (int'(ed_nb) != int'(col_ff)) && (int'(ed_nb) < MAX_VARS);
   assign status.label_ok = (lb_rd != '0) && (int'(lb_rd) <= int'(nl));
   assign status.col_last = (int'(col_ff) + 1 >= int'(nv));
   assign status.nv_zero  = (nv == '0);
   assign status.out_free = out_free;

   // memory address and write selection
   always_comb begin
      un_we = load && req_func == FN_UNARY && int'(req_var_index) < MAX_VARS
              && int'(req_label_a) < MAX_LABELS;
      un_wa = UAW'(int'(req_var_index) * MAX_LABELS + int'(req_label_a));
      un_ra = UAW'(int'(col_ff) * MAX_LABELS + int'(k_ff));

      pr_we = load && req_func == FN_PAIR && int'(req_label_a) < MAX_LABELS
              && req_label_b != 5'd0 && int'(req_label_b) <= MAX_LABELS;
      pr_wa = PAW'((int'(req_label_b) - 1) * MAX_LABELS + int'(req_label_a));
      pr_ra = PAW'((int'(lb_ff) - 1) * MAX_LABELS + int'(k_ff));

      ed_we = load && req_func == FN_EDGE && int'(req_edge_slot) < MAX_EDGES;
      ed_wa = EAW'(req_edge_slot);
      ed_ra = EAW'(s_ff);

      cp_we = load && req_func == FN_COLP && int'(req_var_index) <= MAX_VARS;
      cp_wa = VCW'(req_var_index);
      cp_ra = (op == OP_PTR_HI) ? VCW'(int'(col_ff) + 1) : col_ff;

      lb_we = 1'b0;
      lb_wa = clr_ff;
      lb_wd = '0;
      case (op)
         OP_CLEAR: begin
            lb_we = 1'b1;
         end
         OP_IDLE: begin
            lb_we = load && req_func == FN_LABEL && int'(req_var_index) < MAX_VARS;
            lb_wa = VAW'(req_var_index);
            lb_wd = req_label_a;
         end
         OP_WRITE: begin
            lb_we = 1'b1;
            lb_wa = VAW'(col_ff);
            lb_wd = LABEL_W'(int'(bi_ff) + 1);
         end
         default: begin
            lb_we = 1'b0;
         end
      endcase
      lb_ra = (op == OP_E_CAP) ? VAW'(ed_nb) : VAW'(req_var_index);
   end

   // next-state logic of the datapath registers
   always_comb begin
      num_vars_in   = num_vars_ff;
      num_labels_in = num_labels_ff;
      clr_in        = clr_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      s_in          = s_ff;
      hi_in         = hi_ff;
      w_in          = w_ff;
      lb_in         = lb_ff;
      prod_in       = prod_ff;
      cost_in       = cost_ff;
      best_in       = best_ff;
      bi_in         = bi_ff;
      rd_ok_in      = rd_ok_ff;
      rdlab_in      = rdlab_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_label_in  = rsp_label_ff;

      if (csr_wr_en && csr_index == CSR_NUM_VARS) num_vars_in = csr_wdata;
      if (csr_wr_en && csr_index == CSR_NUM_LABELS) num_labels_in = csr_wdata[4:0];

      case (op)
         OP_CLEAR: begin
            clr_in = VAW'(int'(clr_ff) + 1);
         end
         OP_IDLE: begin
            rd_ok_in = int'(req_var_index) < MAX_VARS;
         end
         OP_RD_CAP: begin
            rdlab_in = (rd_ok_ff && int'(lb_rd) <= int'(nl)) ? lb_rd : '0;
         end
         OP_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RK_READ;
               rsp_label_in = rdlab_ff;
            end
         end
         OP_SW_START: begin
            col_in = '0;
         end
         OP_PTR_HI: begin
            s_in = ptr_clamped;
         end
         OP_PTR_CAP: begin
            hi_in = ptr_clamped;
            k_in  = '0;
         end
         OP_U_CAP: begin
            cost_in[k_idx] = ACC_W'($signed(un_rd)) <<< Q_SHIFT;
            k_in = LCW'(int'(k_ff) + 1);
         end
         OP_E_CHK: begin
            if (s_ff >= hi_ff) k_in = '0;
         end
         OP_E_CAP: begin
            w_in = $signed(ed_rd[COST_W-1:0]);
            if (!status.edge_ok) s_in = s_ff + PTR_W'(1);
         end
         OP_L_CAP: begin
            lb_in = lb_rd;
            if (status.label_ok) begin
               k_in = '0;
            end else begin
               s_in = s_ff + PTR_W'(1);
            end
         end
         OP_P_CAP: begin
            prod_in = w_ff * $signed(pr_rd);
         end
         OP_P_ADD: begin
            cost_in[k_idx] = cost_ff[k_idx] + ACC_W'(prod_ff);
            k_in = LCW'(int'(k_ff) + 1);
            if (status.k_last) s_in = s_ff + PTR_W'(1);
         end
         OP_MIN: begin
            // ties keep the lower label
            if (k_ff == '0 || cost_ff[k_idx] < best_ff) begin
               best_in = cost_ff[k_idx];
               bi_in   = k_idx;
            end
            k_in = LCW'(int'(k_ff) + 1);
         end
         OP_WRITE: begin
            col_in = VCW'(int'(col_ff) + 1);
         end
         OP_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RK_SWEEP;
               rsp_label_in = '0;
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff   <= 11'd1;
         num_labels_ff <= 5'd1;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         num_vars_ff   <= num_vars_in;
         num_labels_ff <= num_labels_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      col_ff       <= col_in;
      k_ff         <= k_in;
      s_ff         <= s_in;
      hi_ff        <= hi_in;
      w_ff         <= w_in;
      lb_ff        <= lb_in;
      prod_ff      <= prod_in;
      cost_ff      <= cost_in;
      best_ff      <= best_in;
      bi_ff        <= bi_in;
      rd_ok_ff     <= rd_ok_in;
      rdlab_ff     <= rdlab_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_label_ff <= rsp_label_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_label       = rsp_label_ff;

   icm_ram #(.WIDTH(COST_W), .DEPTH(MAX_VARS * MAX_LABELS)) u_unary (
      .clock(clock), .wr_en(un_we), .wr_addr(un_wa), .wr_data(req_cost),
      .rd_addr(un_ra), .rd_data(un_rd)
   );

   icm_ram #(.WIDTH(COST_W), .DEPTH(MAX_LABELS * MAX_LABELS)) u_pair (
      .clock(clock), .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(req_cost),
      .rd_addr(pr_ra), .rd_data(pr_rd)
   );

   icm_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .wr_en(ed_we), .wr_addr(ed_wa),
      .wr_data({req_neighbor_index, req_weight}),
      .rd_addr(ed_ra), .rd_data(ed_rd)
   );

   icm_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VARS + 1)) u_colp (
      .clock(clock), .wr_en(cp_we), .wr_addr(cp_wa), .wr_data(req_pointer_value),
      .rd_addr(cp_ra), .rd_data(cp_rd)
   );

   icm_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VARS)) u_label (
      .clock(clock), .wr_en(lb_we), .wr_addr(lb_wa), .wr_data(lb_wd),
      .rd_addr(lb_ra), .rd_data(lb_rd)
   );

endmodule

// ===== sv/icm_label_sweep_unit.sv =====
// icm_label_sweep_unit: top level of the iterated-conditional-modes sweep block
// depends on icm_pkg, icm_ctrl, icm_dpath (and icm_ram below it)

// Load items (unary cost, pairwise cost, edge, column pointer, initial label)
// each take a single memory write. A label read goes through the label memory
// read, a capture and the hand-off to the result register. A sweep item holds
// the input side until it is done. For each column in use it reads the column
// pointers and each label's unary cost, checks each edge and captures the
// neighbor's label, and for a valid label multiplies and adds each label's
// pairwise cost; it then takes the minimum over the labels and writes the
// winner back. An edge whose neighbor is the column itself skips the label
// capture. The single read port of each memory and the registered
// multiply-then-accumulate of one label per step set the pace of a sweep. After
// reset the label memory is cleared, one entry a cycle, through all MAX_VARS
// entries, during which no item is taken; configuration writes are accepted at
// any time but should only be made while the block is idle. A finished result
// waits in an output register, and the next item is taken while it waits.

module icm_label_sweep_unit
   import icm_pkg::*;
#(
   parameter int MAX_VARS   = MAX_VARS_DEF,
   parameter int MAX_LABELS = MAX_LABELS_DEF,
   parameter int MAX_EDGES  = MAX_EDGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // item input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [10:0]        req_var_index,
   input  logic [4:0]         req_label_a,
   input  logic [4:0]         req_label_b,
   input  logic [12:0]        req_edge_slot,
   input  logic [13:0]        req_pointer_value,
   input  logic [9:0]         req_neighbor_index,
   input  logic signed [15:0] req_cost,
   input  logic signed [15:0] req_weight,
   // results
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [4:0]         rsp_label,
   // configuration writes
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [10:0]        csr_wdata
);

   dp_op_type     op;
   dp_status_type status;

   // sequencer: one state per step of the sweep
   icm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_func(req_func),
      .status(status), .req_stall(req_stall), .op(op)
   );

   // memories, accumulators, counters and result register
   icm_dpath #(
      .MAX_VARS(MAX_VARS), .MAX_LABELS(MAX_LABELS), .MAX_EDGES(MAX_EDGES)
   ) u_dpath (
      .clock(clock), .reset(reset), .op(op), .status(status),
      .req_valid(req_valid), .req_func(req_func), .req_var_index(req_var_index),
      .req_label_a(req_label_a), .req_label_b(req_label_b),
      .req_edge_slot(req_edge_slot), .req_pointer_value(req_pointer_value),
      .req_neighbor_index(req_neighbor_index), .req_cost(req_cost),
      .req_weight(req_weight),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_label(rsp_label)
   );

   // a sweep item holds off the input side in the cycle after it is taken
   a_sweep_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == FN_SWEEP) |=> req_stall)
      else $error("sweep item did not hold off input");

   // a label read item also holds off the input side while it is answered
   a_read_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == FN_READ) |=> req_stall)
      else $error("read item did not hold off input");

   // reset starts the clearing pass, which takes no item
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken during clearing pass");

   // a sweep-finished result carries no label
   a_sweep_label_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == RK_SWEEP) |-> (rsp_label == '0))
      else $error("sweep result carries a label");

endmodule
